>>> design/ritt_pkg.sv
`default_nettype none

package ritt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int BYTE_W     = 8;
    localparam int BYTES      = VALUE_BITS / BYTE_W;
    localparam int BYTE_IDX_W = $clog2(BYTES);
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;
    localparam int SYM_COUNT  = 16;
    localparam int CFG_W      = 64;
    localparam int COUNT_W    = 6;
    localparam int STORE_IDX_W = $clog2(VALUE_BITS);

    localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [BYTE_W-1:0] MINUS_CHAR = 8'h2D;

    typedef struct packed {
        logic [BYTE_W-1:0]  quot;
        logic [DIGIT_W-1:0] rem;
    } div_result_t;

endpackage

`default_nettype wire

>>> design/ritt_div_step.sv
`default_nettype none

// one byte of long division by the radix: {rem_in, data_in} / radix
module ritt_div_step (
    input  wire logic [ritt_pkg::DIGIT_W-1:0] rem_in,
    input  wire logic [ritt_pkg::BYTE_W-1:0]  data_in,
    input  wire logic [ritt_pkg::RADIX_W-1:0] radix,
    output ritt_pkg::div_result_t             result
);

    always_comb
    begin
        logic [ritt_pkg::DIGIT_W-1:0] acc;
        logic [ritt_pkg::RADIX_W-1:0] trial;
        logic [ritt_pkg::BYTE_W-1:0]  quot;
        acc  = rem_in;
        quot = '0;
        for (int b = ritt_pkg::BYTE_W - 1; b >= 0; b--)
        begin
            trial = {acc, data_in[b]};
            if (trial >= radix)
            begin
                quot[b] = 1'b1;
                acc     = ritt_pkg::DIGIT_W'(trial - radix);
            end
            else
            begin
                acc = trial[ritt_pkg::DIGIT_W-1:0];
            end
        end
        result.quot = quot;
        result.rem  = acc;
    end

endmodule

`default_nettype wire

>>> design/radix_integer_to_text_top.sv
`default_nettype none

// Converts a signed 32-bit value to text in the radix given by the configured
// symbol table (base_len symbols, 2..16, from symbols_low/symbols_high). Output
// is an optional '-' and then the digit symbols, most significant first, one
// byte per transfer, with tlast on the final one. An invalid table (radix out
// of range, a zero, '+' or '-' symbol, or a duplicate) drops the value with no
// output. A value is accepted, the table is checked, then each digit is divided
// out in the shared byte-wide divider (one dividend byte per cycle), then the
// characters go out one per cycle while the receiver does not stall the output.
// Input is not ready until the last character is in the output register.
module radix_integer_to_text_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [ritt_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic signed [ritt_pkg::VALUE_BITS-1:0] s_tdata, // [31:0] value
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ritt_pkg::BYTE_W-1:0]              m_tdata,  // [7:0] text_byte
    output logic                                     m_tlast
);

    localparam logic [1:0] REG_BASE_LEN = 2'd0;
    localparam logic [1:0] REG_SYM_LOW  = 2'd1;
    localparam logic [1:0] REG_SYM_HIGH = 2'd2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [ritt_pkg::RADIX_W-1:0]        base_len_reg;
    logic [ritt_pkg::CFG_W-1:0]          sym_low_reg;
    logic [ritt_pkg::CFG_W-1:0]          sym_high_reg;
    logic [2*ritt_pkg::CFG_W-1:0]        sym_all;

    logic [2:0]                          state_reg, state_next;
    logic [ritt_pkg::VALUE_BITS-1:0]     mag_reg, mag_next;
    logic                                neg_reg, neg_next;
    logic [ritt_pkg::BYTE_IDX_W-1:0]     byte_idx_reg, byte_idx_next;
    logic [ritt_pkg::DIGIT_W-1:0]        rem_reg, rem_next;
    logic [ritt_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic                                out_valid_reg, out_valid_next;
    logic [ritt_pkg::BYTE_W-1:0]         out_data_reg, out_data_next;
    logic                                out_last_reg, out_last_next;

    logic [ritt_pkg::DIGIT_W-1:0]        digit_store [ritt_pkg::VALUE_BITS];
    logic                                store_we;

    logic                                table_ok;
    logic                                out_free;
    logic [ritt_pkg::BYTE_W-1:0]         div_byte;
    ritt_pkg::div_result_t               div_res;
    logic [ritt_pkg::COUNT_W-1:0]        rd_idx;
    logic [ritt_pkg::DIGIT_W-1:0]        rd_digit;
    logic [ritt_pkg::BYTE_W-1:0]         rd_sym;
    logic [ritt_pkg::VALUE_BITS-1:0]     in_bits;

    assign sym_all  = {sym_high_reg, sym_low_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign in_bits  = s_tdata;

    // table validity, evaluated while the config is stable
    always_comb
    begin
        logic [ritt_pkg::BYTE_W-1:0] si;
        logic [ritt_pkg::BYTE_W-1:0] sk;
        logic ok;
        sk = '0;
        ok = (base_len_reg >= ritt_pkg::RADIX_W'(2))
          && (base_len_reg <= ritt_pkg::RADIX_W'(ritt_pkg::SYM_COUNT));
        for (int i = 0; i < ritt_pkg::SYM_COUNT; i++)
        begin
            si = sym_all[i*ritt_pkg::BYTE_W +: ritt_pkg::BYTE_W];
            if (ritt_pkg::RADIX_W'(i) < base_len_reg)
            begin
                if (si == '0 || si == ritt_pkg::PLUS_CHAR || si == ritt_pkg::MINUS_CHAR)
                begin
                    ok = 1'b0;
                end
                for (int k = i + 1; k < ritt_pkg::SYM_COUNT; k++)
                begin
                    sk = sym_all[k*ritt_pkg::BYTE_W +: ritt_pkg::BYTE_W];
                    if (ritt_pkg::RADIX_W'(k) < base_len_reg && sk == si)
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
        table_ok = ok;
    end

    assign div_byte = mag_reg[byte_idx_reg*ritt_pkg::BYTE_W +: ritt_pkg::BYTE_W];

    ritt_div_step u_div (
        .rem_in  (rem_reg),
        .data_in (div_byte),
        .radix   (base_len_reg),
        .result  (div_res)
    );

    assign rd_idx   = count_reg - ritt_pkg::COUNT_W'(1);
    assign rd_digit = digit_store[rd_idx[ritt_pkg::STORE_IDX_W-1:0]];
    assign rd_sym   = sym_all[rd_digit*ritt_pkg::BYTE_W +: ritt_pkg::BYTE_W];

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        byte_idx_next  = byte_idx_reg;
        rem_next       = rem_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        store_we       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    neg_next   = in_bits[ritt_pkg::VALUE_BITS-1];
                    mag_next   = in_bits[ritt_pkg::VALUE_BITS-1] ?
                                 (~in_bits + ritt_pkg::VALUE_BITS'(1)) : in_bits;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (table_ok)
                begin
                    byte_idx_next = ritt_pkg::BYTE_IDX_W'(ritt_pkg::BYTES - 1);
                    rem_next      = '0;
                    count_next    = '0;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                mag_next[byte_idx_reg*ritt_pkg::BYTE_W +: ritt_pkg::BYTE_W] = div_res.quot;
                rem_next      = div_res.rem;
                byte_idx_next = byte_idx_reg - ritt_pkg::BYTE_IDX_W'(1);
                if (byte_idx_reg == '0)
                begin
                    store_we   = 1'b1;
                    count_next = count_reg + ritt_pkg::COUNT_W'(1);
                    rem_next   = '0;
                    if (mag_next == '0)
                    begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = ritt_pkg::MINUS_CHAR;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_sym;
                    out_last_next  = (count_reg == ritt_pkg::COUNT_W'(1));
                    count_next     = rd_idx;
                    if (count_reg == ritt_pkg::COUNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg  <= '0;
            sym_low_reg   <= '0;
            sym_high_reg  <= '0;
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            byte_idx_reg  <= '0;
            rem_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_LEN: base_len_reg <= cfg_wdata[ritt_pkg::RADIX_W-1:0];
                    REG_SYM_LOW:  sym_low_reg  <= cfg_wdata;
                    REG_SYM_HIGH: sym_high_reg <= cfg_wdata;
                    default:      ;
                endcase
            end
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            byte_idx_reg  <= byte_idx_next;
            rem_reg       <= rem_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (store_we)
        begin
            digit_store[count_reg[ritt_pkg::STORE_IDX_W-1:0]] <= div_res.rem;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ritt_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 500;

    localparam logic [1:0] REG_BASE_LEN = 2'd0;
    localparam logic [1:0] REG_SYM_LOW  = 2'd1;
    localparam logic [1:0] REG_SYM_HIGH = 2'd2;
    localparam logic [1:0] REG_SPARE    = 2'd3;

    // digit 0 in the low byte
    localparam logic [127:0] HEX_TABLE = "FEDCBA9876543210";

    typedef enum int {BAD_SHORT, BAD_WIDE, BAD_DUP, BAD_PLUS, BAD_MINUS, BAD_ZERO} table_fault_e;
    typedef enum logic [1:0] {READY_ALWAYS, READY_CHOPPY, READY_SPARSE} ready_mode_e;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } text_char_t;

    class numeral_ledger;
        logic [RADIX_W-1:0] base_len = '0;
        logic [127:0]       symbols = '0;
        text_char_t         owed_chars[$];
        int                 mismatches = 0;

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_BASE_LEN: base_len = data[RADIX_W-1:0];
                REG_SYM_LOW:  symbols[63:0] = data;
                REG_SYM_HIGH: symbols[127:64] = data;
                default: ;
            endcase
        endfunction

        function logic [BYTE_W-1:0] symbol(int d);
            return symbols[d*8 +: 8];
        endfunction

        function bit table_ok();
            logic [BYTE_W-1:0] s;
            int i, k;
            if (base_len < 2 || base_len > SYM_COUNT)
                return 0;
            for (i = 0; i < base_len; i++)
            begin
                s = symbol(i);
                if (s == 8'h00 || s == PLUS_CHAR || s == MINUS_CHAR)
                    return 0;
                for (k = i + 1; k < base_len; k++)
                    if (symbol(k) == s)
                        return 0;
            end
            return 1;
        endfunction

        // spells one accepted value in the current radix
        function void note_value(logic [VALUE_BITS-1:0] v);
            logic [VALUE_BITS-1:0] mag;
            logic [DIGIT_W-1:0]    digits[VALUE_BITS];
            int                    cnt, i;
            if (!table_ok())
                return;
            mag = v[VALUE_BITS-1] ? ~v + 1'b1 : v;
            cnt = 0;
            do
            begin
                digits[cnt] = DIGIT_W'(mag % base_len);
                mag = mag / base_len;
                cnt++;
            end
            while (mag != 0);
            if (v[VALUE_BITS-1])
                owed_chars.push_back('{MINUS_CHAR, 1'b0});
            for (i = cnt - 1; i >= 0; i--)
                owed_chars.push_back('{symbol(digits[i]), i == 0});
        endfunction

        function void check_char(logic [BYTE_W-1:0] ch, logic last);
            text_char_t want;
            if (owed_chars.size() == 0)
            begin
                $display("%0t: unexpected text byte, expected none, actual %h last %b",
                         $time, ch, last);
                mismatches++;
                return;
            end
            want = owed_chars.pop_front();
            if (want.ch !== ch)
            begin
                $display("%0t: text_byte expected %h actual %h", $time, want.ch, ch);
                mismatches++;
            end
            if (want.last !== last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_BITS-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [BYTE_W-1:0]     m_tdata;
    logic                  m_tlast;

    numeral_ledger ledger = new();
    int            cycle_count = 0;
    int            burst_left = 0;
    ready_mode_e   ready_mode = READY_ALWAYS;
    int            ready_left = 0;
    int            stall_left = 0;

    radix_integer_to_text_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            ledger.check_char(m_tdata, m_tlast);

    // receiver: free-flowing, choppy, or sparse stretches
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= ready_mode_e'($urandom_range(0, 2));
            ready_left <= $urandom_range(16, 160);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_CHOPPY: m_tready <= ($urandom_range(0, 2) != 0);
            default:
            begin
                if (stall_left == 0)
                begin
                    m_tready <= 1'b1;
                    stall_left <= $urandom_range(1, 5);
                end
                else
                begin
                    m_tready <= 1'b0;
                    stall_left <= stall_left - 1;
                end
            end
        endcase
    end

    function automatic logic [127:0] random_table(int n);
        logic [127:0]   t;
        bit [255:0]     taken;
        logic [7:0]     s;
        int             i;
        t = {$urandom, $urandom, $urandom, $urandom};
        taken = '0;
        taken[0] = 1'b1;
        taken[PLUS_CHAR] = 1'b1;
        taken[MINUS_CHAR] = 1'b1;
        for (i = 0; i < n; i++)
        begin
            do
            begin
                s = 8'($urandom_range(1, 255));
            end
            while (taken[s]);
            taken[s] = 1'b1;
            t[i*8 +: 8] = s;
        end
        return t;
    endfunction

    // n must be a valid size (2..16) on entry
    function automatic void break_table(input table_fault_e f, inout logic [RADIX_W-1:0] n,
                                        inout logic [127:0] t);
        int i, j;
        i = $urandom_range(0, n - 2);
        j = $urandom_range(i + 1, n - 1);
        case (f)
            BAD_SHORT: n = RADIX_W'($urandom_range(0, 1));
            BAD_WIDE:  n = RADIX_W'($urandom_range(17, 31));
            BAD_DUP:   t[j*8 +: 8] = t[i*8 +: 8];
            BAD_PLUS:  t[j*8 +: 8] = PLUS_CHAR;
            BAD_MINUS: t[i*8 +: 8] = MINUS_CHAR;
            default:   t[j*8 +: 8] = 8'h00;
        endcase
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value(int n);
        logic [63:0]           p;
        logic [VALUE_BITS-1:0] v;
        int                    k, base;
        base = (n < 2 || n > SYM_COUNT) ? 10 : n;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = VALUE_BITS'($urandom_range(0, 40));
            2: v = $urandom >> $urandom_range(0, 31);
            3:
            begin
                // around a power of the radix
                p = 1;
                k = $urandom_range(1, 31);
                while (k > 0 && p * base <= 64'h8000_0000)
                begin
                    p = p * base;
                    k--;
                end
                v = p[31:0] + $urandom_range(0, 2) - 1;
            end
            default:
                case ($urandom_range(0, 2))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    default: v = '0;
                endcase
        endcase
        if (v != 32'h8000_0000 && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.owed_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_table(input logic [RADIX_W-1:0] n, input logic [127:0] t);
        logic [CFG_W-1:0] junk;
        junk = {$urandom, $urandom};
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_BASE_LEN;
        cfg_wdata <= {junk[CFG_W-1:RADIX_W], n};
        ledger.set_reg(REG_BASE_LEN, {junk[CFG_W-1:RADIX_W], n});
        @(posedge clk);
        cfg_index <= REG_SYM_LOW;
        cfg_wdata <= t[63:0];
        ledger.set_reg(REG_SYM_LOW, t[63:0]);
        @(posedge clk);
        cfg_index <= REG_SYM_HIGH;
        cfg_wdata <= t[127:64];
        ledger.set_reg(REG_SYM_HIGH, t[127:64]);
        @(posedge clk);
        // unmapped index, must be ignored
        cfg_index <= REG_SPARE;
        cfg_wdata <= junk;
        ledger.set_reg(REG_SPARE, junk);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
        end
        else
            burst_left--;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ledger.note_value(v);
    endtask

    initial
    begin
        logic [RADIX_W-1:0] n;
        logic [127:0]       t;
        int                 f, i, phase_len, valid_sent;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty table out of reset: values are dropped
        send_value(32'h0000_0000);
        send_value(32'h8000_0000);

        write_table(5'd10, HEX_TABLE);
        send_value(32'h0000_0000);
        send_value(32'h0000_0001);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFF6);
        send_value(32'd1_000_000_000);

        write_table(5'd2, HEX_TABLE);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hFFFF_FFFF);
        send_value(32'h5555_5555);

        write_table(5'd16, HEX_TABLE);
        send_value(32'h8000_0000);
        send_value(32'hAAAA_AAAA);
        send_value(32'h1234_5678);
        send_value(32'h0000_0000);

        for (f = BAD_SHORT; f <= BAD_ZERO; f++)
        begin
            n = RADIX_W'($urandom_range(2, SYM_COUNT));
            t = random_table(n);
            break_table(table_fault_e'(f), n, t);
            write_table(n, t);
            send_value($urandom);
        end

        valid_sent = 0;
        while (valid_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: n = 5'd2;
                1: n = 5'd16;
                default: n = RADIX_W'($urandom_range(2, SYM_COUNT));
            endcase
            t = random_table(n);
            if ($urandom_range(0, 4) == 0)
            begin
                break_table(table_fault_e'($urandom_range(BAD_SHORT, BAD_ZERO)), n, t);
                phase_len = $urandom_range(2, 6);
            end
            else
                phase_len = $urandom_range(10, 60);
            write_table(n, t);
            for (i = 0; i < phase_len; i++)
            begin
                send_value(pick_value(n));
                if (ledger.table_ok())
                    valid_sent++;
                if ($urandom_range(0, 40) == 0)
                    drain();
            end
        end

        drain();
        if (ledger.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
